// ===== hdl/eebe_pkg.sv =====
// Package for the I2C EEPROM back end: request and result structs,
// function and status codes, and the controller/datapath interface structs.
// No dependencies.
`default_nettype none
package eebe_pkg;

  localparam logic [2:0] FUNC_WR_BYTE   = 3'd0;
  localparam logic [2:0] FUNC_RD_REQ    = 3'd1;
  localparam logic [2:0] FUNC_RD_DONE   = 3'd2;
  localparam logic [2:0] FUNC_STOP      = 3'd3;
  localparam logic [2:0] FUNC_WR_START  = 3'd4;
  localparam logic [2:0] FUNC_HOST_LOAD = 3'd5;
  localparam logic [2:0] FUNC_HOST_READ = 3'd6;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_LOAD_REJ = 2'd1;
  localparam logic [1:0] STS_PAST_END = 2'd2;

  localparam logic [7:0] BYTE_ERASED = 8'hFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  bus_byte;
    logic [15:0] host_addr;
    logic [7:0]  host_data;
    logic [16:0] chunk_offset;
    logic [16:0] chunk_count;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [31:0] offset_now;
    logic [16:0] size_now;
    logic        address_valid;
  } out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic latch_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/eebe_ctrl.sv =====
// Controller for the I2C EEPROM back end: clear sweep after reset, then one
// request at a time through execute, fetch and output register. Uses eebe_pkg.
`default_nettype none
module eebe_ctrl import eebe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_FETCH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load = accept;
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (!out_valid_r || out_ready) begin
          cmd.latch_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    priority if (cmd.latch_out) out_valid_nxt = 1'b1;
    else if (out_ready)         out_valid_nxt = 1'b0;
    else                        out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted request not executed next cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  a_no_accept_clear: assert property (@(posedge clk)
    (!rst_n || state_r == ST_CLEAR) |-> !cmd.load)
    else $error("request taken during clear sweep");

  a_exec_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (state_r == ST_FETCH))
    else $error("execute not followed by fetch");

endmodule
`default_nettype wire

// ===== hdl/eebe_dp.sv =====
// Datapath for the I2C EEPROM back end: address collector, read position,
// stored size, byte memory and result register. Uses eebe_pkg.
`default_nettype none
module eebe_dp import eebe_pkg::*; #(
  parameter int MEM_BYTES  = 65536,
  parameter int ADDR_BYTES = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  output sts_t      sts,
  input  wire in_t  in_data,
  output out_t      out_data
);

  localparam int          AW      = $clog2(MEM_BYTES);
  localparam logic [31:0] MEM_LIM = 32'(MEM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic [AW-1:0] clr_r;
  in_t           item_r;
  logic [7:0]    addr_bytes_r [ADDR_BYTES];
  logic [2:0]    addr_cnt_r, addr_cnt_nxt;
  logic          known_r, known_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [17:0]   size_r, size_nxt;
  logic          use_mem_r, use_mem_nxt;
  logic [7:0]    rbyte_r, rbyte_nxt;
  logic [1:0]    status_r, status_nxt;
  out_t          out_r;

  logic [31:0] host32, size32, pos_eff, addr_full;
  logic [17:0] chunk_end;
  logic        host_in_mem, fetch_ok;

  assign sts.clear_last = (clr_r == CLR_LAST);
  assign out_data       = out_r;

  always_comb begin
    host32      = {16'b0, item_r.host_addr};
    size32      = {14'b0, size_r};
    host_in_mem = host32 < MEM_LIM;
    chunk_end   = {1'b0, item_r.chunk_offset} + {1'b0, item_r.chunk_count};
    addr_full   = '0;
    for (int i = 0; i < ADDR_BYTES - 1; i++) begin
      addr_full = {addr_full[23:0], addr_bytes_r[i]};
    end
    addr_full = {addr_full[23:0], item_r.bus_byte};

    pos_eff = pos_r;
    if (item_r.func == FUNC_RD_DONE && pos_r < size32) pos_eff = pos_r + 32'd1;
    fetch_ok = (pos_eff < size32) && (pos_eff < MEM_LIM);

    addr_cnt_nxt = addr_cnt_r;
    known_nxt    = known_r;
    pos_nxt      = pos_r;
    size_nxt     = size_r;
    use_mem_nxt  = 1'b0;
    rbyte_nxt    = 8'h00;
    status_nxt   = STS_OK;
    mem_we       = cmd.clear;
    mem_wa       = clr_r;
    mem_wd       = BYTE_ERASED;
    mem_ra       = pos_eff[AW-1:0];

    unique case (item_r.func)
      FUNC_WR_BYTE: begin
        if (addr_cnt_r < 3'(ADDR_BYTES)) begin
          addr_cnt_nxt = addr_cnt_r + 3'd1;
          if (addr_cnt_r == 3'(ADDR_BYTES - 1)) begin
            pos_nxt   = addr_full;
            known_nxt = 1'b1;
          end
        end
      end
      FUNC_RD_REQ: begin
        use_mem_nxt = known_r && fetch_ok;
        rbyte_nxt   = BYTE_ERASED;
      end
      FUNC_RD_DONE: begin
        pos_nxt     = pos_eff;
        use_mem_nxt = fetch_ok;
        rbyte_nxt   = BYTE_ERASED;
      end
      FUNC_STOP, FUNC_WR_START: addr_cnt_nxt = 3'd0;
      FUNC_HOST_LOAD: begin
        if ({14'b0, chunk_end} > MEM_LIM) begin
          status_nxt = STS_LOAD_REJ;
        end else begin
          if (cmd.exec && host_in_mem) begin
            mem_we = 1'b1;
            mem_wa = host32[AW-1:0];
            mem_wd = item_r.host_data;
          end
          if (item_r.chunk_offset == 17'd0) size_nxt = {1'b0, item_r.chunk_count};
          else if (chunk_end > size_r)      size_nxt = chunk_end;
        end
      end
      FUNC_HOST_READ: begin
        mem_ra = host32[AW-1:0];
        if (host32 < size32 && host_in_mem) begin
          use_mem_nxt = 1'b1;
        end else begin
          rbyte_nxt  = BYTE_ERASED;
          status_nxt = STS_PAST_END;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.exec) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      addr_cnt_r <= 3'd0;
      known_r    <= 1'b0;
      pos_r      <= 32'd0;
      size_r     <= 18'd0;
      for (int i = 0; i < ADDR_BYTES; i++) addr_bytes_r[i] <= 8'h00;
    end else begin
      if (cmd.clear) clr_r <= clr_r + AW'(1);
      if (cmd.exec) begin
        addr_cnt_r <= addr_cnt_nxt;
        known_r    <= known_nxt;
        pos_r      <= pos_nxt;
        size_r     <= size_nxt;
        if (item_r.func == FUNC_WR_BYTE) begin
          for (int i = 0; i < ADDR_BYTES; i++) begin
            if (addr_cnt_r == 3'(i)) addr_bytes_r[i] <= item_r.bus_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) begin
      use_mem_r <= use_mem_nxt;
      rbyte_r   <= rbyte_nxt;
      status_r  <= status_nxt;
    end
    if (cmd.latch_out) begin
      out_r.read_byte     <= use_mem_r ? mem_q : rbyte_r;
      out_r.status        <= status_r;
      out_r.offset_now    <= pos_r;
      out_r.size_now      <= size_r[16:0];
      out_r.address_valid <= known_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/i2c_slave_eeprom_backend.sv =====
// Top level of the I2C EEPROM back end: controller and datapath.
// Uses eebe_pkg, eebe_ctrl and eebe_dp.
//
// Each request (bus event or host access) passes capture, execute with the
// memory access and registered read data, and result register, which waits
// while a result is pending. The result register lets the next request in
// while a result waits. After reset the memory is filled with 0xFF, one byte
// per cycle, at all MEM_BYTES addresses; in_ready stays low until then.
`default_nettype none
module i2c_slave_eeprom_backend import eebe_pkg::*; #(
  parameter int MEM_BYTES  = 65536,
  parameter int ADDR_BYTES = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  eebe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  eebe_dp #(
    .MEM_BYTES  (MEM_BYTES),
    .ADDR_BYTES (ADDR_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
